>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. They sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

>>> rtl/bu2x_pkg.sv
// ---------------------------------------------------------------------------
// bu2x_pkg
// Shared types, constants and the quad arithmetic of the 2x bilinear upscaler.
// ---------------------------------------------------------------------------
package bu2x_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 56;
    localparam int TDATA_PAD = TDATA_W - 2 * COORD_W - 4 * PIX_W;

    localparam int DEF_WIDTH  = 640;
    localparam int DEF_HEIGHT = 400;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    // decoupling queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int LVL_W   = $clog2(Q_DEPTH + 2);

    // which quads a pixel releases, in output order ul, ur, ll, lr
    typedef struct packed {
        logic lr;   // own quad, last row, last column
        logic ll;   // left quad, last row
        logic ur;   // upper quad, last column
        logic ul;   // upper-left quad
    } quad_sel_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
        logic [PIX_W-1:0]   up;
        logic [PIX_W-1:0]   ul;
        logic [PIX_W-1:0]   lf;
        quad_sel_t          sel;
    } entry_t;

    typedef struct packed {
        logic [PIX_W-1:0]   br;
        logic [PIX_W-1:0]   bl;
        logic [PIX_W-1:0]   tr;
        logic [PIX_W-1:0]   tl;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } quad_t;

    function automatic quad_t make_quad(
        input logic [COORD_W-1:0] row,
        input logic [COORD_W-1:0] col,
        input logic [PIX_W-1:0]   a,
        input logic [PIX_W-1:0]   right,
        input logic [PIX_W-1:0]   low,
        input logic [PIX_W-1:0]   diag
    );
        quad_t            q;
        logic [PIX_W:0]   s2r;
        logic [PIX_W:0]   s2l;
        logic [PIX_W+1:0] s4;
        s2r   = {1'b0, a} + {1'b0, right};
        s2l   = {1'b0, a} + {1'b0, low};
        s4    = {2'b00, a} + {2'b00, right} + {2'b00, low} + {2'b00, diag};
        q.row = row;
        q.col = col;
        q.tl  = a;
        q.tr  = s2r[PIX_W:1];
        q.bl  = s2l[PIX_W:1];
        q.br  = s4[PIX_W+1:2];
        return q;
    endfunction

endpackage

>>> rtl/bilinear_upscale_2x.sv
// ---------------------------------------------------------------------------
// bilinear_upscale_2x - streaming 2x bilinear upscaler, one source row buffered
// Path: s1 registers, then the queue, then the output register of the back.
// Throughput: one pixel and one quad per cycle; right-edge and last-row pixels
// release up to 4 quads, so the 4-entry queue and the output port set the pace.
// Reset: position 0,0, size 640x400; the line store is not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_upscale_2x
    import bu2x_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // source pixels
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
    // output quads
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [9:0] src_row, [19:10] src_col, [27:20] top_left, [35:28] top_right,
    // [43:36] bottom_left, [51:44] bottom_right, [55:52] zero
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tlast,   // last_of_run
    // register writes: index 0 image_width, 1 image_height
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Front: counts position, reads the pixel above from the line store and
    // writes the new pixel in its place, then flags which quads are complete.
    // Queue: holds classified pixels so that, while it has room, the front keeps
    // one pixel per clock as the back spends extra cycles on edge pixels.
    // Back: emits the flagged quads in order, upper row first, tlast on the
    // final one of each pixel.

    logic             q_push;
    entry_t           q_push_entry;
    logic             q_pop;
    logic             q_head_valid;
    entry_t           q_head;
    logic [LVL_W-1:0] q_level;

    bu2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_level    (q_level),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    bu2x_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head),
        .level      (q_level)
    );

    bu2x_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // front flow control must keep the queue from overflowing
    `ASSERT_NEVER(a_queue_overflow, q_push && !q_pop && (q_level == LVL_W'(Q_DEPTH)))
    // back only retires an entry that is there
    `ASSERT_IMPL(a_pop_nonempty, q_pop, q_head_valid)
    // retiring an entry loads its final quad into the output register
    `ASSERT_NEXT(a_pop_loads_out, q_pop, m_tvalid && m_tlast)

endmodule

>>> rtl/bu2x_ram.sv
// ---------------------------------------------------------------------------
// bu2x_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ---------------------------------------------------------------------------
module bu2x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bu2x_queue.sv
// ---------------------------------------------------------------------------
// bu2x_queue
// Short FIFO of classified pixels between front and back.
// ---------------------------------------------------------------------------
module bu2x_queue
    import bu2x_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  entry_t           push_entry,
    input  logic             pop,
    output logic             head_valid,
    output entry_t           head,
    output logic [LVL_W-1:0] level
);

    entry_t            slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [LVL_W-1:0]  level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level      = level_reg;

endmodule

>>> rtl/bu2x_front.sv
// ---------------------------------------------------------------------------
// bu2x_front
// Pixel intake: position counters, line store, neighbour capture, quad select.
// ---------------------------------------------------------------------------
module bu2x_front
    import bu2x_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [LVL_W-1:0]     q_level,
    output logic                 push,
    output entry_t               push_entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RST_W_LAST = ((DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH) - 1;
    localparam int RST_H_LAST = ((DEF_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEF_HEIGHT) - 1;

    // last valid index for a written size; zero counts as one
    function automatic int size_last(input logic [CFG_W-1:0] v, input int maxv);
        int r;
        if (v == '0)
        begin
            r = 0;
        end
        else if (int'(v) > maxv)
        begin
            r = maxv - 1;
        end
        else
        begin
            r = int'(v) - 1;
        end
        return r;
    endfunction

    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic [CW-1:0]      w_last_reg;
    logic [RW-1:0]      h_last_reg;
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic [COORD_W-1:0] s1_col_reg;
    quad_sel_t          s1_sel_reg;
    logic [PIX_W-1:0]   ul_reg;
    logic [PIX_W-1:0]   lf_reg;
    logic [PIX_W-1:0]   up_pix;
    logic               accept;
    logic               col_end;
    logic               row_end;
    quad_sel_t          sel;

    assign s_tready  = ((q_level + LVL_W'(s1_valid_reg)) < LVL_W'(Q_DEPTH));
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign col_end   = (col_reg == w_last_reg);
    assign row_end   = (row_reg == h_last_reg);

    always_comb
    begin
        sel.ul = (row_reg != '0) && (col_reg != '0);
        sel.ur = (row_reg != '0) && col_end;
        sel.ll = row_end && (col_reg != '0);
        sel.lr = row_end && col_end;
    end

    bu2x_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (s_tdata),
        .raddr (col_reg),
        .rdata (up_pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            w_last_reg   <= CW'(RST_W_LAST);
            h_last_reg   <= RW'(RST_H_LAST);
            s1_valid_reg <= 1'b0;
            ul_reg       <= '0;
            lf_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                ul_reg <= up_pix;
                lf_reg <= s1_pix_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WIDTH:
                    begin
                        w_last_reg <= CW'(size_last(cfg_data, MAX_WIDTH));
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    REG_HEIGHT:
                    begin
                        h_last_reg <= RW'(size_last(cfg_data, MAX_HEIGHT));
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (accept)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= s_tdata;
            s1_row_reg <= COORD_W'(row_reg);
            s1_col_reg <= COORD_W'(col_reg);
            s1_sel_reg <= sel;
        end
    end

    assign push = s1_valid_reg && (s1_sel_reg != '0);

    always_comb
    begin
        push_entry.row = s1_row_reg;
        push_entry.col = s1_col_reg;
        push_entry.pix = s1_pix_reg;
        push_entry.up  = up_pix;
        push_entry.ul  = ul_reg;
        push_entry.lf  = lf_reg;
        push_entry.sel = s1_sel_reg;
    end

endmodule

>>> rtl/bu2x_back.sv
// ---------------------------------------------------------------------------
// bu2x_back
// Quad generator: walks the selected quads of the head entry, one per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module bu2x_back
    import bu2x_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  entry_t             head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    quad_sel_t done_reg;
    quad_sel_t rem;
    quad_sel_t pick;
    logic      m_tvalid_reg;
    logic      m_tlast_reg;
    quad_t     quad_reg;
    quad_t     quad;
    logic      load;
    logic      last;

    assign rem = head.sel & ~done_reg;

    // first pending quad in output order, and its arithmetic
    always_comb
    begin
        pick = '0;
        if (rem.ul)
        begin
            pick.ul = 1'b1;
            quad = make_quad(head.row - COORD_W'(1), head.col - COORD_W'(1),
                             head.ul, head.up, head.lf, head.pix);
        end
        else if (rem.ur)
        begin
            pick.ur = 1'b1;
            quad = make_quad(head.row - COORD_W'(1), head.col,
                             head.up, head.up, head.pix, head.up);
        end
        else if (rem.ll)
        begin
            pick.ll = 1'b1;
            quad = make_quad(head.row, head.col - COORD_W'(1),
                             head.lf, head.pix, head.lf, head.lf);
        end
        else
        begin
            pick.lr = 1'b1;
            quad = make_quad(head.row, head.col,
                             head.pix, head.pix, head.pix, head.pix);
        end
    end

    assign load = head_valid && (!m_tvalid_reg || m_tready);
    assign last = ((rem & ~pick) == '0);
    assign pop  = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
                done_reg     <= last ? '0 : (done_reg | pick);
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_reg    <= quad;
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {TDATA_PAD'(0), quad_reg};

endmodule
